// File: hw/rtl/fir_pkg.sv
// Shared types, constants and the coefficient table of the low-pass FIR filter.
// Used by fir_ctrl, fir_dp and the top level; depends on nothing else.

package fir_pkg;

    localparam int unsigned COEF_BITS = 20;
    localparam int unsigned MAX_TAPS  = 64;
    localparam int unsigned TAP_IDX_W = 6;

    typedef logic [TAP_IDX_W-1:0] tap_idx_t;

    typedef enum logic [1:0]
    {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_DONE
    } fir_state_t;

    typedef struct packed
    {
        logic     shift_in;
        logic     mac;
        logic     load_out;
        tap_idx_t tap_idx;
    } fir_cmd_t;

    typedef struct packed
    {
        logic out_busy;
    } fir_stat_t;

    function automatic logic signed [COEF_BITS-1:0] coef_rom(input tap_idx_t idx);
        logic signed [COEF_BITS-1:0] c;
        case (idx)
            6'd0:    c = 20'sd24538;
            6'd1:    c = 20'sd25771;
            6'd2:    c = 20'sd29318;
            6'd3:    c = 20'sd35140;
            6'd4:    c = 20'sd43158;
            6'd5:    c = 20'sd53256;
            6'd6:    c = 20'sd65279;
            6'd7:    c = 20'sd79042;
            6'd8:    c = 20'sd94325;
            6'd9:    c = 20'sd110883;
            6'd10:   c = 20'sd128450;
            6'd11:   c = 20'sd146737;
            6'd12:   c = 20'sd165444;
            6'd13:   c = 20'sd184263;
            6'd14:   c = 20'sd202883;
            6'd15:   c = 20'sd220992;
            6'd16:   c = 20'sd238291;
            6'd17:   c = 20'sd254488;
            6'd18:   c = 20'sd269314;
            6'd19:   c = 20'sd282519;
            6'd20:   c = 20'sd293881;
            6'd21:   c = 20'sd303209;
            6'd22:   c = 20'sd310346;
            6'd23:   c = 20'sd315172;
            6'd24:   c = 20'sd317606;
            6'd25:   c = 20'sd315172;
            6'd26:   c = 20'sd310346;
            6'd27:   c = 20'sd303209;
            6'd28:   c = 20'sd293881;
            6'd29:   c = 20'sd282519;
            6'd30:   c = 20'sd269314;
            6'd31:   c = 20'sd254488;
            6'd32:   c = 20'sd238291;
            6'd33:   c = 20'sd220992;
            6'd34:   c = 20'sd202883;
            6'd35:   c = 20'sd184263;
            6'd36:   c = 20'sd165444;
            6'd37:   c = 20'sd146737;
            6'd38:   c = 20'sd128450;
            6'd39:   c = 20'sd110883;
            6'd40:   c = 20'sd94325;
            6'd41:   c = 20'sd79042;
            6'd42:   c = 20'sd65279;
            6'd43:   c = 20'sd53256;
            6'd44:   c = 20'sd43158;
            6'd45:   c = 20'sd35140;
            6'd46:   c = 20'sd29318;
            6'd47:   c = 20'sd25771;
            6'd48:   c = 20'sd24538;
            default: c = '0;
        endcase
        return c;
    endfunction

endpackage

// File: hw/rtl/fir_filter_fixed_point_unit.sv
// Top level of the 49-tap fixed-point low-pass FIR filter: stream ports around
// the sequencer fir_ctrl and the datapath fir_dp. Depends on fir_pkg.
//
//  channel | dir | payload
//  --------+-----+---------------------------------------------------------
//  s_*     | in  | tdata: sample (SAMPLE_BITS, signed), zero padded to bytes
//  m_*     | out | tdata: filtered (SAMPLE_BITS+1, signed), zero padded
//
// Each sample is processed in order: the delay line is loaded, TAPS products go
// through the single shared multiplier, the product register is drained, and the
// result is rounded, saturated and registered once the output register is not stalled.
// Reset clears the delay line, accumulator and both valid flags.
// A held result in the output register does not block the next sample; only
// the hand-off of a new result waits for m_tready.

module fir_filter_fixed_point_unit
    import fir_pkg::*;
#(
    parameter int unsigned TAPS        = 49,
    parameter int unsigned FRAC_BITS   = 23,
    parameter int unsigned SAMPLE_BITS = 16
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]    s_tdata,   // sample
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [((SAMPLE_BITS+8)/8)*8-1:0]    m_tdata    // filtered
);

    localparam int unsigned M_W = ((SAMPLE_BITS + 8) / 8) * 8;

    fir_cmd_t               cmd;
    fir_stat_t              stat;
    logic [SAMPLE_BITS:0]   filtered;

    fir_ctrl #(
        .TAPS (TAPS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    fir_dp #(
        .TAPS        (TAPS),
        .FRAC_BITS   (FRAC_BITS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample    (signed'(s_tdata[SAMPLE_BITS-1:0])),
        .cmd       (cmd),
        .stat      (stat),
        .filtered  (filtered),
        .out_valid (m_tvalid),
        .out_ready (m_tready)
    );

    assign m_tdata = M_W'(filtered);

endmodule

// File: hw/rtl/fir_ctrl.sv
// Sequencer of the FIR filter: accepts a sample, steps the tap counter, hands off the result.
// Depends on fir_pkg.

module fir_ctrl
    import fir_pkg::*;
#(
    parameter int unsigned TAPS = 49
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    output fir_cmd_t  cmd,
    input  fir_stat_t stat
);

    localparam int unsigned CNT_W = $clog2(TAPS);

    fir_state_t       state_reg, state_next;
    logic [CNT_W-1:0] tap_reg, tap_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            tap_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            tap_reg   <= tap_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        tap_next     = tap_reg;
        in_ready     = 1'b0;
        cmd.shift_in = 1'b0;
        cmd.mac      = 1'b0;
        cmd.load_out = 1'b0;
        cmd.tap_idx  = TAP_IDX_W'(tap_reg);
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                tap_next = '0;
                if (in_valid)
                begin
                    cmd.shift_in = 1'b1;
                    state_next   = ST_RUN;
                end
            end
            ST_RUN:
            begin
                cmd.mac = 1'b1;
                if (tap_reg == CNT_W'(TAPS - 1))
                begin
                    tap_next   = '0;
                    state_next = ST_DRAIN;
                end
                else
                begin
                    tap_next = tap_reg + 1'b1;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!stat.out_busy)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// File: hw/rtl/fir_dp.sv
// Datapath of the FIR filter: rotating delay line, shared multiplier, accumulator,
// rounding toward zero, saturation and output register. Depends on fir_pkg.

module fir_dp
    import fir_pkg::*;
#(
    parameter int unsigned TAPS        = 49,
    parameter int unsigned FRAC_BITS   = 23,
    parameter int unsigned SAMPLE_BITS = 16
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    input  fir_cmd_t                      cmd,
    output fir_stat_t                     stat,
    output logic        [SAMPLE_BITS:0]   filtered,
    output logic                          out_valid,
    input  logic                          out_ready
);

    localparam int unsigned PROD_W = SAMPLE_BITS + COEF_BITS;
    localparam int unsigned ACC_W  = PROD_W + $clog2(TAPS) + 2;
    localparam int unsigned OUT_W  = SAMPLE_BITS + 1;

    localparam logic signed [ACC_W-1:0] BIAS   = ACC_W'((64'sd1 <<< FRAC_BITS) - 64'sd1);
    localparam logic signed [ACC_W-1:0] OUT_HI = ACC_W'((64'sd1 <<< (OUT_W - 1)) - 64'sd1);
    localparam logic signed [ACC_W-1:0] OUT_LO = ACC_W'(-(64'sd1 <<< (OUT_W - 1)));

    logic signed [SAMPLE_BITS-1:0] dly_reg [TAPS];
    logic signed [PROD_W-1:0]      prod_reg;
    logic                          prod_vld_reg;
    logic signed [ACC_W-1:0]       acc_reg;
    logic        [OUT_W-1:0]       out_data_reg;
    logic                          out_vld_reg;

    logic signed [ACC_W-1:0]       rnd;
    logic signed [ACC_W-1:0]       quo;
    logic        [OUT_W-1:0]       sat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TAPS; i++)
            begin
                dly_reg[i] <= '0;
            end
        end
        else if (cmd.shift_in)
        begin
            dly_reg[0] <= sample;
            for (int i = 1; i < TAPS; i++)
            begin
                dly_reg[i] <= dly_reg[i-1];
            end
        end
        else if (cmd.mac)
        begin
            dly_reg[TAPS-1] <= dly_reg[0];
            for (int i = 0; i < TAPS - 1; i++)
            begin
                dly_reg[i] <= dly_reg[i+1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mac)
        begin
            prod_reg <= coef_rom(cmd.tap_idx) * dly_reg[0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_vld_reg <= 1'b0;
            acc_reg      <= '0;
        end
        else
        begin
            prod_vld_reg <= cmd.mac;
            if (cmd.shift_in)
            begin
                acc_reg <= '0;
            end
            else if (prod_vld_reg)
            begin
                acc_reg <= acc_reg + ACC_W'(prod_reg);
            end
        end
    end

    always_comb
    begin
        rnd = acc_reg + (acc_reg[ACC_W-1] ? BIAS : '0);
        quo = rnd >>> FRAC_BITS;
        if (quo > OUT_HI)
        begin
            sat = OUT_HI[OUT_W-1:0];
        end
        else if (quo < OUT_LO)
        begin
            sat = OUT_LO[OUT_W-1:0];
        end
        else
        begin
            sat = quo[OUT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_vld_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_data_reg <= sat;
        end
    end

    assign stat.out_busy = out_vld_reg && !out_ready;
    assign filtered      = out_data_reg;
    assign out_valid     = out_vld_reg;

endmodule

// File: hw/rtl/fir_chk.sv
// Port-level checker for fir_filter_fixed_point_unit and its bind statement.
// Depends only on the top level's ports.

module fir_chk
#(
    parameter int unsigned SAMPLE_BITS = 16
)
(
    input logic                             clk,
    input logic                             rst_n,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [((SAMPLE_BITS+8)/8)*8-1:0] m_tdata
);

    localparam int unsigned M_W = ((SAMPLE_BITS + 8) / 8) * 8;
    localparam int unsigned O_W = SAMPLE_BITS + 1;

    a_m_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second beat taken while a sample is in work");

    a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result appeared without a sample in work");

    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ((m_tdata >> O_W) == M_W'(0)))
        else $error("padding bits of m_tdata not zero");

endmodule

bind fir_filter_fixed_point_unit fir_chk #(.SAMPLE_BITS(SAMPLE_BITS)) u_fir_chk (.*);
